// ===== rtl/core/jbl_pkg.sv =====
// shared types, constants and keyword tables of the json byte lexer
package jbl_pkg;

    // run length counter width and reported length width
    localparam int LEN_BITS = 16;
    localparam int TLEN_BITS = 16;
    localparam int MAX_RECS = 3;
    localparam int QDEPTH = 4;
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef logic [LEN_BITS-1:0] t_len;
    typedef logic [TLEN_BITS-1:0] t_tlen;
    typedef logic [3:0] t_kind;
    typedef logic [QCNT_BITS-1:0] t_qcnt;

    localparam t_len LEN_MAX = '1;

    // token kinds
    localparam t_kind K_STRING = 4'd0;
    localparam t_kind K_COMMA = 4'd1;
    localparam t_kind K_BOOL = 4'd2;
    localparam t_kind K_NULL = 4'd3;
    localparam t_kind K_CCLOSE = 4'd4;
    localparam t_kind K_COPEN = 4'd5;
    localparam t_kind K_BCLOSE = 4'd6;
    localparam t_kind K_BOPEN = 4'd7;
    localparam t_kind K_COLON = 4'd8;
    localparam t_kind K_NUMBER = 4'd9;
    localparam t_kind K_UNKNOWN = 4'd10;

    // keyword selectors
    localparam logic [1:0] KW_TRUE = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL = 2'd2;

    // lexer modes
    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_STRING = 5'b00010,
        M_KEYWORD = 5'b00100,
        M_NUMBER = 5'b01000,
        M_UNKNOWN = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic in_last;
    } t_in_item;

    typedef struct packed {
        logic rec_is_end;
        logic [7:0] out_byte;
        t_kind token_kind;
        t_tlen token_length;
        logic out_last;
    } t_out_item;

    typedef struct packed {
        t_mode mode;
        logic quote_is_single;
        logic prev_was_backslash;
        logic [1:0] keyword_which;
        logic [2:0] keyword_pos;
        t_len run_length;
    } t_lex_state;

    localparam t_lex_state ST_RESET = '{
        mode: M_IDLE,
        quote_is_single: 1'b0,
        prev_was_backslash: 1'b0,
        keyword_which: KW_TRUE,
        keyword_pos: 3'd0,
        run_length: '0
    };

    // keyword letter at a position; unused selector acts as true
    function automatic logic [7:0] kw_char(logic [1:0] which, logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (which)
            KW_FALSE: begin
                unique case (pos)
                    3'd0: c = 8'h66;
                    3'd1: c = 8'h61;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h73;
                    3'd4: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            KW_NULL: begin
                unique case (pos)
                    3'd0: c = 8'h6E;
                    3'd1: c = 8'h75;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h6C;
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0: c = 8'h74;
                    3'd1: c = 8'h72;
                    3'd2: c = 8'h75;
                    3'd3: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] which);
        return (which == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic t_kind kw_kind(logic [1:0] which);
        return (which == KW_NULL) ? K_NULL : K_BOOL;
    endfunction

    // saturate the run length to the reported width
    function automatic t_tlen sat_len(t_len v);
        t_tlen r;
        if (LEN_BITS > TLEN_BITS && v > t_len'({TLEN_BITS{1'b1}})) begin
            r = '1;
        end else begin
            r = TLEN_BITS'(v);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/jbl_step.sv =====
// per-byte lexer step: next state and up to three records for one request
module jbl_step import jbl_pkg::*; (
    input  t_lex_state               i_st,
    input  t_in_item                 i_item,
    output t_lex_state               o_st,
    output t_out_item [MAX_RECS-1:0] o_recs,
    output logic [1:0]               o_nrec
);

    typedef struct packed {
        t_lex_state st;
        t_out_item [MAX_RECS-1:0] recs;
        logic [1:0] n;
    } t_work;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CCLOSE = 8'h7D;
    localparam logic [7:0] CH_COPEN = 8'h7B;
    localparam logic [7:0] CH_BCLOSE = 8'h5D;
    localparam logic [7:0] CH_BOPEN = 8'h5B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;

    // append a content record and count it
    function automatic t_work put_content(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        r.recs[r.n] = '{rec_is_end: 1'b0, out_byte: b, token_kind: K_STRING,
                        token_length: '0, out_last: 1'b0};
        r.n = r.n + 2'd1;
        if (r.st.run_length != LEN_MAX) begin
            r.st.run_length = r.st.run_length + t_len'(1);
        end
        return r;
    endfunction

    // append an end record and return to idle
    function automatic t_work put_finish(t_work w, t_kind kind);
        t_work r;
        r = w;
        r.recs[r.n] = '{rec_is_end: 1'b1, out_byte: 8'h00, token_kind: kind,
                        token_length: sat_len(r.st.run_length), out_last: 1'b0};
        r.n = r.n + 2'd1;
        r.st = ST_RESET;
        return r;
    endfunction

    logic [7:0] b;
    logic       b_ws;
    logic       b_digit;
    logic       do_start;
    logic [2:0] kpos;
    t_kind      punct;
    logic       is_punct;
    t_work      w;

    assign b = i_item.in_byte;
    assign b_ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    assign b_digit = (b >= 8'h30) && (b <= 8'h39);
    assign kpos = (i_st.keyword_pos < 3'd5) ? i_st.keyword_pos : 3'd4;

    // punctuation decode
    always_comb begin
        is_punct = 1'b1;
        unique case (b)
            CH_COMMA:  punct = K_COMMA;
            CH_CCLOSE: punct = K_CCLOSE;
            CH_COPEN:  punct = K_COPEN;
            CH_BCLOSE: punct = K_BCLOSE;
            CH_BOPEN:  punct = K_BOPEN;
            CH_COLON:  punct = K_COLON;
            default: begin
                punct = K_UNKNOWN;
                is_punct = 1'b0;
            end
        endcase
    end

    // mode update, token start and close on the final byte
    always_comb begin
        w = '0;
        w.st = i_st;
        do_start = 1'b0;

        unique case (i_st.mode)
            M_STRING: begin
                if (b == (i_st.quote_is_single ? CH_SQUOTE : CH_DQUOTE)
                        && !i_st.prev_was_backslash) begin
                    w = put_finish(w, K_STRING);
                end else begin
                    w = put_content(w, b);
                    w.st.prev_was_backslash = (b == CH_BSLASH);
                end
            end
            M_KEYWORD: begin
                if (b == kw_char(i_st.keyword_which, kpos)) begin
                    w = put_content(w, b);
                    w.st.keyword_pos = kpos + 3'd1;
                    if (w.st.keyword_pos >= kw_len(i_st.keyword_which)) begin
                        w = put_finish(w, kw_kind(i_st.keyword_which));
                    end
                end else if (b_ws) begin
                    w = put_finish(w, K_UNKNOWN);
                end else begin
                    w.st.mode = M_UNKNOWN;
                    w.st.keyword_which = KW_TRUE;
                    w.st.keyword_pos = 3'd0;
                    w = put_content(w, b);
                end
            end
            M_NUMBER: begin
                if (b_digit || b == CH_DOT) begin
                    w = put_content(w, b);
                end else begin
                    w = put_finish(w, K_NUMBER);
                    do_start = 1'b1;
                end
            end
            M_UNKNOWN: begin
                if (b_ws) begin
                    w = put_finish(w, K_UNKNOWN);
                end else begin
                    w = put_content(w, b);
                end
            end
            default: begin
                w.st.mode = M_IDLE;
                do_start = 1'b1;
            end
        endcase

        // start of a new token from idle or after a number ends
        if (do_start && !b_ws) begin
            if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                w.st.mode = M_STRING;
                w.st.quote_is_single = (b == CH_SQUOTE);
                w.st.prev_was_backslash = 1'b0;
                w.st.run_length = '0;
            end else if (is_punct) begin
                w = put_content(w, b);
                w = put_finish(w, punct);
            end else if (b == CH_T || b == CH_F || b == CH_N) begin
                w.st.mode = M_KEYWORD;
                w.st.keyword_which = (b == CH_T) ? KW_TRUE
                                   : (b == CH_F) ? KW_FALSE : KW_NULL;
                w.st.keyword_pos = 3'd1;
                w = put_content(w, b);
            end else if (b == CH_MINUS || b_digit) begin
                w.st.mode = M_NUMBER;
                w = put_content(w, b);
            end else begin
                w.st.mode = M_UNKNOWN;
                w = put_content(w, b);
            end
        end

        // close any open token on the final byte
        if (i_item.in_last && w.st.mode != M_IDLE) begin
            priority if (w.st.mode == M_STRING) begin
                w = put_finish(w, K_STRING);
            end else if (w.st.mode == M_NUMBER) begin
                w = put_finish(w, K_NUMBER);
            end else begin
                w = put_finish(w, K_UNKNOWN);
            end
        end

        // mark the last record of this request
        if (w.n != 2'd0) begin
            w.recs[w.n - 2'd1].out_last = 1'b1;
        end
    end

    assign o_st = w.st;
    assign o_recs = w.recs;
    assign o_nrec = w.n;

endmodule

// ===== rtl/core/jbl_recq.sv =====
// four-entry record queue: takes up to three records at once, gives one per cycle while i_head_ready is high
module jbl_recq import jbl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [1:0]               i_push_n,
    input  t_out_item [MAX_RECS-1:0] i_push_recs,
    input  logic                     i_head_ready,
    output logic                     o_head_valid,
    output t_out_item                o_head,
    output logic                     o_room
);

    t_out_item r_q [QDEPTH];
    t_out_item n_q [QDEPTH];
    t_qcnt     r_cnt;
    t_qcnt     n_cnt;
    t_qcnt     kept;
    t_qcnt     slot;
    logic      pop;

    assign o_head_valid = (r_cnt != '0);
    assign o_head = r_q[0];
    assign pop = o_head_valid && i_head_ready;
    // room for a full request of three records after the current one
    assign o_room = (r_cnt <= t_qcnt'(1));

    // shift on pop, append new records behind what stays
    always_comb begin
        kept = r_cnt - t_qcnt'(pop);
        slot = '0;
        for (int j = 0; j < QDEPTH; j++) begin
            if (pop && j < QDEPTH - 1) begin
                n_q[j] = r_q[$clog2(QDEPTH)'(j + 1)];
            end else begin
                n_q[j] = r_q[j];
            end
            slot = t_qcnt'(j) - kept;
            if (i_push && t_qcnt'(j) >= kept && slot < t_qcnt'(i_push_n)) begin
                n_q[j] = i_push_recs[slot[1:0]];
            end
        end
        n_cnt = kept + (i_push ? t_qcnt'(i_push_n) : '0);
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QDEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a request is only taken when three records fit
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt <= t_qcnt'(1))
        else $error("record queue overrun");

    // a pop with no push drops the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push) |=> r_cnt == $past(r_cnt) - t_qcnt'(1))
        else $error("record queue count slip on pop");

    // a lone queued record always closes its request
    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == t_qcnt'(1)) |-> r_q[0].out_last)
        else $error("queued records end without out_last");

endmodule

// ===== rtl/core/json_byte_lexer.sv =====
// top level of the streaming json byte lexer
//
// channel   dir  handshake                 payload
// input     in   i_in_valid / o_in_ready   i_in_data  (t_in_item: byte, last)
// output    out  o_out_valid / i_out_ready o_out_data (t_out_item: one record)
//
// A byte is lexed in the cycle it is accepted; its records enter the record
// queue and leave it one record per cycle while the receiver is ready.
// One byte per cycle while each byte gives at most one record and the receiver
// is ready; a byte that gives more holds the input until at most one is left.
// o_in_ready depends only on queue occupancy (at most one record left).
// Synchronous active-low reset returns the lexer to idle and empties the queue.
module json_byte_lexer import jbl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_lex_state               r_st;
    t_lex_state               n_st;
    t_out_item [MAX_RECS-1:0] step_recs;
    logic [1:0]               step_n;
    logic                     room;
    logic                     accept;

    assign o_in_ready = room;
    assign accept = i_in_valid && room;

    // combinational step over the current state and the incoming byte
    jbl_step u_step (
        .i_st   (r_st),
        .i_item (i_in_data),
        .o_st   (n_st),
        .o_recs (step_recs),
        .o_nrec (step_n)
    );

    // record queue toward the output
    jbl_recq u_recq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept),
        .i_push_n     (step_n),
        .i_push_recs  (step_recs),
        .i_head_ready (i_out_ready),
        .o_head_valid (o_out_valid),
        .o_head       (o_out_data),
        .o_room       (room)
    );

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    // the final byte always leaves the lexer idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.in_last) |=> r_st.mode == M_IDLE)
        else $error("token left open after final byte");

    // no value bytes are counted between tokens
    a_idle_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == M_IDLE) |-> (r_st.run_length == '0))
        else $error("run length nonzero while idle");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the streaming json byte lexer
module testbench;
    import jbl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // source characters the lexer cares about
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;

    localparam int RANDOM_BYTES = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_NS = 1_000_000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_TIGHT,
        RX_PERIODIC
    } t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    json_byte_lexer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mirrored lexer state
    t_mode      lx_mode = M_IDLE;
    logic       lx_single = 1'b0;
    logic       lx_escape = 1'b0;
    logic [1:0] lx_kw = KW_TRUE;
    logic [2:0] lx_pos = '0;
    t_len       lx_len = '0;

    t_out_item  step_recs[$];
    t_out_item  queued_records[$];
    int         mismatch_count = 0;

    // sender burst and receiver stall bookkeeping
    int         burst_left = 0;
    t_rx_mode   rx_mode = RX_OPEN;
    int         rx_left = 0;
    int unsigned rx_cycle = 0;

    logic [7:0] token_bytes[$];

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic string keyword_word(input logic [1:0] w);
        string s;
        case (w)
            KW_FALSE: s = "false";
            KW_NULL: s = "null";
            default: s = "true";
        endcase
        return s;
    endfunction

    function automatic logic [7:0] keyword_letter(input logic [1:0] w, input logic [2:0] p);
        string s;
        s = keyword_word(w);
        if (int'(p) < s.len()) begin
            return s[p];
        end
        return 8'h00;
    endfunction

    // record builders for the predicted output
    task automatic put_record(input logic is_end, input logic [7:0] b, input t_kind k,
                              input t_len len);
        t_out_item r;
        r.rec_is_end = is_end;
        r.out_byte = b;
        r.token_kind = k;
        r.token_length = (64'(len) > 64'hFFFF) ? 16'hFFFF : t_tlen'(len);
        r.out_last = 1'b0;
        step_recs.push_back(r);
    endtask

    task automatic content_byte(input logic [7:0] b);
        put_record(1'b0, b, K_STRING, '0);
        if (lx_len != '1) begin
            lx_len = lx_len + 1'b1;
        end
    endtask

    task automatic close_token(input t_kind k);
        put_record(1'b1, 8'h00, k, lx_len);
        lx_len = '0;
        lx_mode = M_IDLE;
        lx_single = 1'b0;
        lx_escape = 1'b0;
        lx_kw = KW_TRUE;
        lx_pos = '0;
    endtask

    // first byte of a token while idle or after a number ends
    task automatic open_token(input logic [7:0] b);
        t_kind pk;
        logic  punct;
        punct = 1'b1;
        pk = K_COMMA;
        case (b)
            CH_COMMA: pk = K_COMMA;
            CH_RBRACE: pk = K_CCLOSE;
            CH_LBRACE: pk = K_COPEN;
            CH_RBRACK: pk = K_BCLOSE;
            CH_LBRACK: pk = K_BOPEN;
            CH_COLON: pk = K_COLON;
            default: punct = 1'b0;
        endcase
        if (is_space(b)) begin
            // separator only
        end else if (b == CH_DQUOTE || b == CH_APOS) begin
            lx_mode = M_STRING;
            lx_single = (b == CH_APOS);
            lx_escape = 1'b0;
            lx_len = '0;
        end else if (punct) begin
            content_byte(b);
            close_token(pk);
        end else if (b == CH_T || b == CH_F || b == CH_N) begin
            lx_mode = M_KEYWORD;
            lx_kw = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
            lx_pos = 3'd1;
            content_byte(b);
        end else if (b == CH_MINUS || is_digit(b)) begin
            lx_mode = M_NUMBER;
            content_byte(b);
        end else begin
            lx_mode = M_UNKNOWN;
            content_byte(b);
        end
    endtask

    // records caused by one accepted source byte
    task automatic tokenize_byte(input logic [7:0] b, input logic last);
        logic [7:0] q;
        string      word;
        t_out_item  r;
        step_recs.delete();
        case (lx_mode)
            M_STRING: begin
                q = lx_single ? CH_APOS : CH_DQUOTE;
                if (b == q && !lx_escape) begin
                    close_token(K_STRING);
                end else begin
                    content_byte(b);
                    lx_escape = (b == CH_BSLASH);
                end
            end
            M_KEYWORD: begin
                word = keyword_word(lx_kw);
                if (b == keyword_letter(lx_kw, lx_pos)) begin
                    content_byte(b);
                    lx_pos = lx_pos + 3'd1;
                    if (int'(lx_pos) >= word.len()) begin
                        close_token((lx_kw == KW_NULL) ? K_NULL : K_BOOL);
                    end
                end else if (is_space(b)) begin
                    close_token(K_UNKNOWN);
                end else begin
                    // broken keyword turns into an unknown run
                    lx_mode = M_UNKNOWN;
                    lx_kw = KW_TRUE;
                    lx_pos = '0;
                    content_byte(b);
                end
            end
            M_NUMBER: begin
                if (is_digit(b) || b == CH_DOT) begin
                    content_byte(b);
                end else begin
                    close_token(K_NUMBER);
                    open_token(b);
                end
            end
            M_UNKNOWN: begin
                if (is_space(b)) begin
                    close_token(K_UNKNOWN);
                end else begin
                    content_byte(b);
                end
            end
            default: begin
                lx_mode = M_IDLE;
                open_token(b);
            end
        endcase
        // end of source closes whatever is open
        if (last && lx_mode != M_IDLE) begin
            if (lx_mode == M_STRING) begin
                close_token(K_STRING);
            end else if (lx_mode == M_NUMBER) begin
                close_token(K_NUMBER);
            end else begin
                close_token(K_UNKNOWN);
            end
        end
        if (step_recs.size() > 0) begin
            r = step_recs.pop_back();
            r.out_last = 1'b1;
            step_recs.push_back(r);
        end
        foreach (step_recs[i]) begin
            queued_records.push_back(step_recs[i]);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // compare each taken record, then predict for each taken request
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (queued_records.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected record, expected none actual %h",
                             $time, o_out_data);
                end else begin
                    want = queued_records.pop_front();
                    check_field("rec_is_end", want.rec_is_end, o_out_data.rec_is_end);
                    check_field("out_byte", want.out_byte, o_out_data.out_byte);
                    check_field("token_kind", want.token_kind, o_out_data.token_kind);
                    check_field("token_length", want.token_length, o_out_data.token_length);
                    check_field("out_last", want.out_last, o_out_data.out_last);
                end
            end
            if (i_in_valid && o_in_ready) begin
                tokenize_byte(i_in_data.in_byte, i_in_data.in_last);
            end
        end
    end

    // receiver stalls in phases of different character
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN: i_out_ready <= 1'b1;
            RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
            RX_TIGHT: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (rx_cycle % 3 == 0);
        endcase
    end

    // one source byte; gaps come between bursts
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= '{in_byte: b, in_last: last};
        // wait for the request to be taken
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    task automatic send_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], last && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] any_space();
        int v;
        v = $urandom_range(0, 5);
        return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
    endfunction

    function automatic logic [7:0] number_char();
        int v;
        v = $urandom_range(0, 10);
        return (v == 10) ? CH_DOT : CH_ZERO + 8'(v);
    endfunction

    // any byte that neither closes nor escapes inside a string
    function automatic logic [7:0] plain_string_byte(input logic [7:0] q);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == q || b == CH_BSLASH);
        return b;
    endfunction

    // random token text, mostly well formed
    task automatic build_token(output logic noisy);
        logic [7:0] q;
        string      s;
        int         n;
        int         pick;
        token_bytes.delete();
        noisy = 1'b0;
        pick = $urandom_range(0, 15);
        case (pick)
            0, 1, 2, 14: begin
                q = $urandom_range(0, 1) ? CH_APOS : CH_DQUOTE;
                token_bytes.push_back(q);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            token_bytes.push_back(CH_BSLASH);
                            token_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        1: token_bytes.push_back(any_space());
                        default: token_bytes.push_back(plain_string_byte(q));
                    endcase
                end
                // an unclosed string now and then
                if (pick != 14) begin
                    token_bytes.push_back(q);
                end
            end
            3, 4: begin
                s = keyword_word(2'($urandom_range(0, 2)));
                for (int i = 0; i < s.len(); i++) token_bytes.push_back(s[i]);
            end
            5, 6: begin
                if ($urandom_range(0, 2) == 0) token_bytes.push_back(CH_MINUS);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) token_bytes.push_back(number_char());
            end
            7, 8, 9: begin
                case ($urandom_range(0, 5))
                    0: token_bytes.push_back(CH_COMMA);
                    1: token_bytes.push_back(CH_LBRACE);
                    2: token_bytes.push_back(CH_RBRACE);
                    3: token_bytes.push_back(CH_LBRACK);
                    4: token_bytes.push_back(CH_RBRACK);
                    default: token_bytes.push_back(CH_COLON);
                endcase
            end
            10, 11: begin
                token_bytes.push_back(any_space());
            end
            12: begin
                // keyword prefix broken by any byte
                s = keyword_word(2'($urandom_range(0, 2)));
                n = $urandom_range(1, s.len() - 1);
                for (int i = 0; i < n; i++) token_bytes.push_back(s[i]);
                token_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                noisy = 1'b1;
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) token_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // punctuation, strings with escapes, keywords, number end, lone minus,
    // broken keywords, empty string, stray bytes, partial keyword at end
    task automatic test_directed();
        send_text("{\"a\\\" b\":-1.,", 1'b0);
        send_text("[true]", 1'b0);
        send_text("- ", 1'b0);
        send_text("nx", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(" t ", 1'b0);
        send_text("''", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text(" fa", 1'b1);
    endtask

    // random token streams with documents ended by the last flag
    task automatic test_random_tokens();
        int   sent;
        logic noisy;
        logic end_doc;
        logic lst;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_token(noisy);
            end_doc = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < token_bytes.size(); i++) begin
                if (noisy) begin
                    lst = ($urandom_range(0, 3) == 0);
                end else begin
                    lst = end_doc && (i == token_bytes.size() - 1);
                end
                send_byte(token_bytes[i], lst);
                sent++;
            end
        end
    endtask

    task automatic drain_records();
        i_in_valid <= 1'b0;
        while (queued_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_tokens();
        test_random_tokens();
        drain_records();
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/jbl_pkg.sv
rtl/core/jbl_step.sv
rtl/core/jbl_recq.sv
rtl/core/json_byte_lexer.sv
dv/testbench.sv
